>>> hw/rtl/lcar_pkg.sv
// Shared constants, register indexes and controller/datapath command types.
package lcar_pkg;

    localparam int CODE_W     = 24;
    localparam int HALF_W     = 8;
    localparam int SPR_W      = 5;
    localparam int SDIV_W     = 16;
    localparam int PAUSE_W    = 32;
    localparam int WEIGHT_W   = 31;
    localparam int BITCNT_W   = 5;
    localparam int SCALE_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int MAX_SAMPLES_DEF = 16;

    localparam logic [CODE_W-1:0]   SIGN_FLIP   = 24'h800000;
    localparam logic [BITCNT_W-1:0] CODE_BITS   = 5'd24;
    localparam logic [SCALE_W-1:0]  CENTI_SCALE = 7'd100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_DIV = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE     = 2'd3;

    localparam logic [HALF_W-1:0]  HALF_BIT_RST  = 8'd100;
    localparam logic [SPR_W-1:0]   SAMPLES_RST   = 5'd10;
    localparam logic [SDIV_W-1:0]  SCALE_DIV_RST = 16'd1300;
    localparam logic [PAUSE_W-1:0] PAUSE_RST     = 32'd0;

    typedef struct packed {
        logic step;         // a tick word is taken this cycle
        logic cnt_clear;    // start of a conversion
        logic cnt_adv;      // advance the half-period counter
        logic shift_in;     // shift data_pin into the code
        logic sample_add;   // conversion done, accumulate
        logic tare_load;
        logic div_start;
        logic pause_load;
        logic pause_dec;
        logic clock_level;
    } lcar_cmd_t;

    typedef struct packed {
        logic half_done;
        logic last_bit;
        logic reading_full;
        logic tare_taken;
        logic diff_pos;
        logic pause_last;
        logic pause_armed;
        logic div_done;
    } lcar_status_t;

endpackage

>>> hw/rtl/lcar_in_if.sv
// Tick input channel: sampled converter data-out level.
interface lcar_in_if;
    logic valid;
    logic ready;
    logic data_pin;

    modport source (output valid, output data_pin, input ready);
    modport sink   (input valid, input data_pin, output ready);
endinterface

>>> hw/rtl/lcar_out_if.sv
// Result channel: clock level, raw code and weight per tick.
interface lcar_out_if;
    logic                          valid;
    logic                          ready;
    logic                          clock_pin;
    logic                          raw_valid;
    logic [lcar_pkg::CODE_W-1:0]   raw_code;
    logic                          weight_valid;
    logic [lcar_pkg::WEIGHT_W-1:0] weight_centigrams;

    modport source (output valid, output clock_pin, output raw_valid, output raw_code,
                    output weight_valid, output weight_centigrams, input ready);
    modport sink   (input valid, input clock_pin, input raw_valid, input raw_code,
                    input weight_valid, input weight_centigrams, output ready);
endinterface

>>> hw/rtl/lcar_div.sv
// Iterative unit: (a * 100) / (n * d), one quotient bit per cycle.
module lcar_div #(
    parameter int A_W = 28,
    parameter int N_W = 5
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [A_W-1:0]                             a,
    input  logic [N_W-1:0]                             n,
    input  logic [lcar_pkg::SDIV_W-1:0]                d,
    output logic                                       done,
    output logic [A_W+lcar_pkg::SCALE_W-1:0]           quo
);

    localparam int PROD_W = A_W + lcar_pkg::SCALE_W;
    localparam int DEN_W  = N_W + lcar_pkg::SDIV_W;
    localparam int CNT_W  = $clog2(PROD_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [A_W-1:0]              a_reg;
    logic [N_W-1:0]              n_reg;
    logic [lcar_pkg::SDIV_W-1:0] d_reg;
    logic [DEN_W-1:0]            den_reg;
    logic [DEN_W-1:0]            rem_reg;
    logic [PROD_W-1:0]           quo_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        done_reg;

    logic [DEN_W:0]              rem_sh;
    logic [DEN_W:0]              trial;
    logic                        ge;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[PROD_W-1]};
        trial  = rem_sh - {1'b0, den_reg};
        ge     = rem_sh >= {1'b0, den_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_MUL;
            ST_MUL:  state_next = ST_RUN;
            ST_RUN:  if (cnt_reg == CNT_W'(PROD_W - 1)) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_RUN) && (state_next == ST_IDLE);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    a_reg <= a;
                    n_reg <= n;
                    d_reg <= d;
                end
            end
            ST_MUL:
            begin
                quo_reg <= PROD_W'(a_reg) * PROD_W'(lcar_pkg::CENTI_SCALE);
                den_reg <= DEN_W'(n_reg) * DEN_W'(d_reg);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            ST_RUN:
            begin
                rem_reg <= ge ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                quo_reg <= {quo_reg[PROD_W-2:0], ge};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> hw/rtl/lcar_dp.sv
// Datapath: config registers, bit timing counters, shift word, sums, tare, pause, output word.
module lcar_dp #(
    parameter int MAX_SAMPLES = lcar_pkg::MAX_SAMPLES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lcar_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              data_pin,
    input  lcar_pkg::lcar_cmd_t               cmd,
    output lcar_pkg::lcar_status_t            status,
    output logic                              clock_pin,
    output logic                              raw_valid,
    output logic [lcar_pkg::CODE_W-1:0]       raw_code,
    output logic                              weight_valid,
    output logic [lcar_pkg::WEIGHT_W-1:0]     weight_centigrams
);

    localparam int CODE_W = lcar_pkg::CODE_W;
    localparam int SUM_W  = CODE_W + $clog2(MAX_SAMPLES);
    localparam int N_W    = $clog2(MAX_SAMPLES + 1);
    localparam int CW     = (N_W > lcar_pkg::SPR_W) ? N_W : lcar_pkg::SPR_W;
    localparam int PROD_W = SUM_W + lcar_pkg::SCALE_W;

    logic [lcar_pkg::HALF_W-1:0]   half_bit_reg;
    logic [lcar_pkg::SPR_W-1:0]    samples_reg;
    logic [lcar_pkg::SDIV_W-1:0]   scale_div_reg;
    logic [lcar_pkg::PAUSE_W-1:0]  pause_ticks_reg;

    logic [lcar_pkg::HALF_W-1:0]   tick_reg;
    logic [lcar_pkg::BITCNT_W-1:0] bit_reg;
    logic [CODE_W-1:0]             shift_reg;
    logic [SUM_W-1:0]              sum_reg;
    logic [N_W-1:0]                count_reg;
    logic [SUM_W-1:0]              tare_reg;
    logic                          tare_taken_reg;
    logic [lcar_pkg::PAUSE_W-1:0]  pause_reg;

    logic                          clock_pin_reg;
    logic                          raw_valid_reg;
    logic [CODE_W-1:0]             raw_code_reg;
    logic                          weight_valid_reg;
    logic [lcar_pkg::WEIGHT_W-1:0] weight_reg;

    logic [lcar_pkg::HALF_W-1:0]   half_eff;
    logic [lcar_pkg::HALF_W-1:0]   tick_plus;
    logic [lcar_pkg::BITCNT_W-1:0] bit_plus;
    logic [CODE_W-1:0]             code;
    logic [SUM_W-1:0]              sum_new;
    logic [SUM_W-1:0]              diff;
    logic [CW-1:0]                 spr_x;
    logic [CW-1:0]                 max_x;
    logic [CW-1:0]                 n_clamp;
    logic [N_W-1:0]                n_eff;
    logic [N_W:0]                  count_plus;
    logic [lcar_pkg::SDIV_W-1:0]   div_eff;
    logic                          div_done;
    logic [PROD_W-1:0]             quo;

    always_comb
    begin
        half_eff   = (half_bit_reg == '0) ? lcar_pkg::HALF_W'(1) : half_bit_reg;
        tick_plus  = tick_reg + lcar_pkg::HALF_W'(1);
        bit_plus   = bit_reg + lcar_pkg::BITCNT_W'(1);
        code       = shift_reg ^ lcar_pkg::SIGN_FLIP;
        sum_new    = sum_reg + SUM_W'(code);
        diff       = sum_new - tare_reg;
        spr_x      = CW'(samples_reg);
        max_x      = CW'(MAX_SAMPLES);
        if (spr_x == '0)
            n_clamp = CW'(1);
        else if (spr_x > max_x)
            n_clamp = max_x;
        else
            n_clamp = spr_x;
        n_eff      = n_clamp[N_W-1:0];
        count_plus = {1'b0, count_reg} + (N_W+1)'(1);
        div_eff    = (scale_div_reg == '0) ? lcar_pkg::SDIV_W'(1) : scale_div_reg;
    end

    always_comb
    begin
        status.half_done    = (tick_plus >= half_eff) || (tick_plus == '0);
        status.last_bit     = bit_plus >= lcar_pkg::CODE_BITS;
        status.reading_full = count_plus >= {1'b0, n_eff};
        status.tare_taken   = tare_taken_reg;
        status.diff_pos     = sum_new > tare_reg;
        status.pause_last   = pause_reg <= lcar_pkg::PAUSE_W'(1);
        status.pause_armed  = pause_ticks_reg != '0;
        status.div_done     = div_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bit_reg    <= lcar_pkg::HALF_BIT_RST;
            samples_reg     <= lcar_pkg::SAMPLES_RST;
            scale_div_reg   <= lcar_pkg::SCALE_DIV_RST;
            pause_ticks_reg <= lcar_pkg::PAUSE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lcar_pkg::REG_HALF_BIT:  half_bit_reg    <= cfg_wdata[lcar_pkg::HALF_W-1:0];
                lcar_pkg::REG_SAMPLES:   samples_reg     <= cfg_wdata[lcar_pkg::SPR_W-1:0];
                lcar_pkg::REG_SCALE_DIV: scale_div_reg   <= cfg_wdata[lcar_pkg::SDIV_W-1:0];
                lcar_pkg::REG_PAUSE:     pause_ticks_reg <= cfg_wdata[lcar_pkg::PAUSE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            bit_reg        <= '0;
            shift_reg      <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            tare_reg       <= '0;
            tare_taken_reg <= 1'b0;
            pause_reg      <= '0;
        end
        else
        begin
            if (cmd.cnt_clear)
            begin
                tick_reg  <= '0;
                bit_reg   <= '0;
                shift_reg <= '0;
            end
            else if (cmd.cnt_adv)
            begin
                tick_reg <= status.half_done ? '0 : tick_plus;
                if (cmd.shift_in)
                begin
                    shift_reg <= {shift_reg[CODE_W-2:0], data_pin};
                    bit_reg   <= bit_plus;
                end
            end

            if (cmd.sample_add)
            begin
                if (status.reading_full)
                begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    sum_reg   <= sum_new;
                    count_reg <= count_plus[N_W-1:0];
                end
            end

            if (cmd.tare_load)
            begin
                tare_reg       <= sum_new;
                tare_taken_reg <= 1'b1;
            end

            if (cmd.pause_load)
                pause_reg <= pause_ticks_reg;
            else if (cmd.pause_dec && (pause_reg != '0))
                pause_reg <= pause_reg - lcar_pkg::PAUSE_W'(1);
        end
    end

    // output word: loaded per tick, weight filled in when the divider finishes
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            clock_pin_reg    <= cmd.clock_level;
            raw_valid_reg    <= cmd.sample_add;
            raw_code_reg     <= cmd.sample_add ? code : '0;
            weight_valid_reg <= 1'b0;
            weight_reg       <= '0;
        end
        else if (div_done)
        begin
            weight_valid_reg <= 1'b1;
            weight_reg       <= quo[lcar_pkg::WEIGHT_W-1:0];
        end
    end

    lcar_div #(
        .A_W (SUM_W),
        .N_W (N_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .a     (diff),
        .n     (n_eff),
        .d     (div_eff),
        .done  (div_done),
        .quo   (quo)
    );

    assign clock_pin         = clock_pin_reg;
    assign raw_valid         = raw_valid_reg;
    assign raw_code          = raw_code_reg;
    assign weight_valid      = weight_valid_reg;
    assign weight_centigrams = weight_reg;

endmodule

>>> hw/rtl/lcar_ctrl.sv
// Controller: converter phase sequencer and word handshake.
module lcar_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   data_pin,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  lcar_pkg::lcar_status_t status,
    output lcar_pkg::lcar_cmd_t    cmd
);

    localparam logic [2:0] PH_WAIT     = 3'd0;
    localparam logic [2:0] PH_HIGH     = 3'd1;
    localparam logic [2:0] PH_LOW      = 3'd2;
    localparam logic [2:0] PH_P25_HIGH = 3'd3;
    localparam logic [2:0] PH_P25_LOW  = 3'd4;
    localparam logic [2:0] PH_PAUSE    = 3'd5;

    localparam logic CS_RUN = 1'b0;
    localparam logic CS_DIV = 1'b1;

    logic [2:0] phase_reg, phase_next;
    logic       cs_reg, cs_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_ready = (cs_reg == CS_RUN) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd             = '0;
        cmd.clock_level = (phase_reg == PH_HIGH) || (phase_reg == PH_P25_HIGH);
        phase_next      = phase_reg;
        if (accept)
        begin
            cmd.step = 1'b1;
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (!data_pin)
                    begin
                        cmd.cnt_clear = 1'b1;
                        phase_next    = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    cmd.cnt_adv = 1'b1;
                    if (status.half_done) phase_next = PH_LOW;
                end
                PH_LOW:
                begin
                    cmd.cnt_adv = 1'b1;
                    if (status.half_done)
                    begin
                        cmd.shift_in = 1'b1;
                        phase_next   = status.last_bit ? PH_P25_HIGH : PH_HIGH;
                    end
                end
                PH_P25_HIGH:
                begin
                    cmd.cnt_adv = 1'b1;
                    if (status.half_done) phase_next = PH_P25_LOW;
                end
                PH_P25_LOW:
                begin
                    cmd.cnt_adv = 1'b1;
                    if (status.half_done)
                    begin
                        cmd.sample_add = 1'b1;
                        phase_next     = PH_WAIT;
                        if (status.reading_full)
                        begin
                            if (!status.tare_taken)
                                cmd.tare_load = 1'b1;
                            else
                            begin
                                cmd.div_start = status.diff_pos;
                                if (status.pause_armed)
                                begin
                                    cmd.pause_load = 1'b1;
                                    phase_next     = PH_PAUSE;
                                end
                            end
                        end
                    end
                end
                PH_PAUSE:
                begin
                    cmd.pause_dec = 1'b1;
                    if (status.pause_last) phase_next = PH_WAIT;
                end
                default: phase_next = PH_WAIT;
            endcase
        end
    end

    always_comb
    begin
        cs_next        = cs_reg;
        out_valid_next = out_valid_reg;
        priority if (accept)
        begin
            // a positive weight holds the word back until the quotient is in
            out_valid_next = !cmd.div_start;
            cs_next        = cmd.div_start ? CS_DIV : CS_RUN;
        end
        else if ((cs_reg == CS_DIV) && status.div_done)
        begin
            out_valid_next = 1'b1;
            cs_next        = CS_RUN;
        end
        else if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            cs_reg        <= CS_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cs_reg        <= cs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/load_cell_adc_reader.sv
// Load-cell converter reader: each input word is one timer tick carrying the sampled
// data-out pin, and each tick returns one output word with the serial clock level, the
// raw code when a 24-bit conversion ends and, after the tare reading, the weight in
// hundredths of a gram when a reading with a positive weight ends. A tick's word is
// registered and appears in the cycle after the tick is taken, except for a tick that
// closes a reading with a positive weight: the weight goes through an iterative divider
// (a multiply step, then one quotient bit per cycle), and that tick's word appears once
// the quotient is in. No tick is taken while that division runs. The input takes a new
// tick while the previous output word is being taken. Configuration registers are written
// through cfg_we / cfg_index / cfg_wdata and should be changed only between ticks.
module load_cell_adc_reader #(
    parameter int MAX_SAMPLES = lcar_pkg::MAX_SAMPLES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcar_pkg::CFG_DATA_W-1:0] cfg_wdata,
    lcar_in_if.sink                         sample_in,
    lcar_out_if.source                      result_out
);

    lcar_pkg::lcar_cmd_t    cmd;
    lcar_pkg::lcar_status_t status;

    lcar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_in.valid),
        .in_ready  (sample_in.ready),
        .data_pin  (sample_in.data_pin),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lcar_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .data_pin          (sample_in.data_pin),
        .cmd               (cmd),
        .status            (status),
        .clock_pin         (result_out.clock_pin),
        .raw_valid         (result_out.raw_valid),
        .raw_code          (result_out.raw_code),
        .weight_valid      (result_out.weight_valid),
        .weight_centigrams (result_out.weight_centigrams)
    );

endmodule
